// ===== design/hrad_pkg.sv =====
`default_nettype none

package hrad_pkg;

	// Result list depth and byte counter saturation point.
	localparam int          MAX_RESULTS = 8;
	localparam logic [3:0]  CNT_SAT     = 4'd9;
	localparam logic [3:0]  MAX_ACT_RST = 4'd8;

	// Boot keyboard key codes for Enter and keypad Enter.
	localparam logic [7:0]  KEY_ENTER    = 8'h28;
	localparam logic [7:0]  KEY_KP_ENTER = 8'h58;

	// Consumer page usage codes.
	localparam logic [15:0] USG_POWER      = 16'h0030;
	localparam logic [15:0] USG_MENU       = 16'h0040;
	localparam logic [15:0] USG_MENU_PICK  = 16'h0041;
	localparam logic [15:0] USG_NEXT       = 16'h00B5;
	localparam logic [15:0] USG_PREV       = 16'h00B6;
	localparam logic [15:0] USG_STOP       = 16'h00B7;
	localparam logic [15:0] USG_EJECT      = 16'h00B8;
	localparam logic [15:0] USG_PLAY_PAUSE = 16'h00CD;
	localparam logic [15:0] USG_MUTE       = 16'h00E2;
	localparam logic [15:0] USG_VOL_UP     = 16'h00E9;
	localparam logic [15:0] USG_VOL_DOWN   = 16'h00EA;
	localparam logic [15:0] USG_AC_HOME    = 16'h0223;
	localparam logic [15:0] USG_AC_BACK    = 16'h0224;

	// Action codes.
	localparam logic [2:0]  ACT_NONE        = 3'd0;
	localparam logic [2:0]  ACT_BRIGHT_UP   = 3'd1;
	localparam logic [2:0]  ACT_BRIGHT_DOWN = 3'd2;
	localparam logic [2:0]  ACT_SCREEN_NEXT = 3'd3;
	localparam logic [2:0]  ACT_SCREEN_PREV = 3'd4;
	localparam logic [2:0]  ACT_SELECT      = 3'd5;

	// Snapshot of one finished report, handed from the tracker to the emitter.
	typedef struct packed {
		logic [3:0]                        byte_cnt;
		logic [7:0]                        first_byte;
		logic                              second_zero;
		logic                              enter_seen;
		logic                              array_valid;
		logic                              usage_none;
		logic [3:0]                        nz_cnt;
		logic [MAX_RESULTS-1:0][2:0]       nz_list;
	} report_sum_t;

	function automatic logic usage_known(input logic [15:0] u);
		return u inside {USG_POWER, USG_MENU, USG_MENU_PICK, USG_NEXT, USG_PREV,
			USG_STOP, USG_EJECT, USG_PLAY_PAUSE, USG_MUTE, USG_VOL_UP,
			USG_VOL_DOWN, USG_AC_HOME, USG_AC_BACK};
	endfunction

	function automatic logic [2:0] usage_action(input logic [15:0] u);
		logic [2:0] a;
		case (u)
			USG_VOL_UP:                    a = ACT_BRIGHT_UP;
			USG_VOL_DOWN:                  a = ACT_BRIGHT_DOWN;
			USG_NEXT:                      a = ACT_SCREEN_NEXT;
			USG_PREV:                      a = ACT_SCREEN_PREV;
			USG_PLAY_PAUSE, USG_MENU_PICK: a = ACT_SELECT;
			default:                       a = ACT_NONE;
		endcase
		return a;
	endfunction

	// Bitmap bits: Next, Prev, Stop, Play/Pause, Mute, Vol Up, Vol Down.
	function automatic logic [2:0] bitmap_action(input logic [2:0] bit_idx);
		logic [2:0] a;
		case (bit_idx)
			3'd0:    a = ACT_SCREEN_NEXT;
			3'd1:    a = ACT_SCREEN_PREV;
			3'd3:    a = ACT_SELECT;
			3'd5:    a = ACT_BRIGHT_UP;
			3'd6:    a = ACT_BRIGHT_DOWN;
			default: a = ACT_NONE;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

// ===== design/hrad_if.sv =====
`default_nettype none

// Report byte channel.
interface hrad_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] report_byte;
	logic       last_byte;

	modport source (output valid, output report_byte, output last_byte, input ready);
	modport sink (input valid, input report_byte, input last_byte, output ready);
endinterface

// Action result channel.
interface hrad_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic       has_action;
	logic       last_result;

	modport source (output valid, output action, output has_action, output last_result,
		input ready);
	modport sink (input valid, input action, input has_action, input last_result,
		output ready);
endinterface

`default_nettype wire

// ===== design/hid_report_action_decoder_unit.sv =====
`default_nettype none

// Channel  | Role | Handshake     | Transaction payload
// report   | in   | valid / ready | report_byte[7:0], last_byte
// result   | out  | valid / ready | action[2:0], has_action, last_result
// cfg      | in   | cfg_wr_en     | cfg_wr_data[3:0] = max_actions
//
// Report bytes are taken one per cycle and stream back to back while the snapshot
// register is free. The final byte's snapshot moves to the output list at the next edge
// at which the list is idle or sends its last result; results then follow one per
// cycle while result.ready is high, 1 to 8 for a report, the first offered in the cycle
// after the snapshot moves. While a snapshot waits for the list, report.ready is held low.
// Reset clears the report state and sets max_actions to 8; result stalls back up here.

module hid_report_action_decoder_unit #(
	parameter int USAGE_SLOTS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	hrad_in_if.sink         report,
	hrad_out_if.source      result,
	input  wire logic       cfg_wr_en,
	input  wire logic [3:0] cfg_wr_data
);

	logic [3:0]            max_actions_q;
	hrad_pkg::report_sum_t sum_s1;
	logic                  sum_valid_s1;
	logic                  sum_take;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_actions_q <= hrad_pkg::MAX_ACT_RST;
		end else if (cfg_wr_en) begin
			max_actions_q <= cfg_wr_data;
		end
	end

	hrad_tracker #(
		.USAGE_SLOTS (USAGE_SLOTS)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.report       (report),
		.sum_s1       (sum_s1),
		.sum_valid_s1 (sum_valid_s1),
		.sum_take     (sum_take)
	);

	hrad_emitter #(
		.USAGE_SLOTS (USAGE_SLOTS)
	) u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.max_actions  (max_actions_q),
		.sum_s1       (sum_s1),
		.sum_valid_s1 (sum_valid_s1),
		.sum_take     (sum_take),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== design/hrad_tracker.sv =====
`default_nettype none

module hrad_tracker #(
	parameter int USAGE_SLOTS = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	hrad_in_if.sink                  report,
	output hrad_pkg::report_sum_t    sum_s1,
	output logic                     sum_valid_s1,
	input  wire logic                sum_take
);

	localparam int NZ_DEPTH = (USAGE_SLOTS < hrad_pkg::MAX_RESULTS) ?
		USAGE_SLOTS : hrad_pkg::MAX_RESULTS;
	localparam int UC_W     = $clog2(USAGE_SLOTS + 1);
	localparam int NZC_W    = $clog2(NZ_DEPTH + 1);
	localparam int NZI_W    = (NZ_DEPTH > 1) ? $clog2(NZ_DEPTH) : 1;

	logic [3:0]       cnt_q, cnt_n;
	logic             odd_q;
	logic [7:0]       first_q, first_n;
	logic [7:0]       pend_q, pend_n;
	logic             av_q, av_n;
	logic [UC_W-1:0]  uc_q, uc_n;
	logic [NZC_W-1:0] nzc_q, nzc_n;
	logic [2:0]       nz_q [NZ_DEPTH];
	logic [2:0]       nz_n [NZ_DEPTH];
	logic [hrad_pkg::MAX_RESULTS-1:0][2:0] nz_pack;
	logic             sbz_q, sbz_n;
	logic             enter_q, enter_n;
	logic [15:0]      word;
	logic [2:0]       word_act;
	logic             accept;

	// A new byte is taken whenever the snapshot slot is free or being drained.
	assign report.ready = !sum_valid_s1 || sum_take;
	assign accept       = report.valid && report.ready;

	assign word     = {report.report_byte, pend_q};
	assign word_act = hrad_pkg::usage_action(word);

	// Next report state with the incoming byte folded in.
	always_comb begin
		cnt_n   = (cnt_q < hrad_pkg::CNT_SAT) ? cnt_q + 4'd1 : cnt_q;
		first_n = (cnt_q == 4'd0) ? report.report_byte : first_q;
		sbz_n   = (cnt_q == 4'd1) ? (report.report_byte == 8'd0) : sbz_q;
		enter_n = enter_q;
		if (cnt_q >= 4'd2 && cnt_q <= 4'd7 &&
			(report.report_byte == hrad_pkg::KEY_ENTER ||
			report.report_byte == hrad_pkg::KEY_KP_ENTER)) begin
			enter_n = 1'b1;
		end
		pend_n = odd_q ? pend_q : report.report_byte;
		av_n   = av_q;
		uc_n   = uc_q;
		nzc_n  = nzc_q;
		nz_n   = nz_q;
		if (odd_q && word != 16'd0) begin
			if (!hrad_pkg::usage_known(word)) begin
				av_n = 1'b0;
			end else if (av_q && uc_q < UC_W'(USAGE_SLOTS)) begin
				uc_n = uc_q + UC_W'(1);
				if (word_act != hrad_pkg::ACT_NONE && nzc_q < NZC_W'(NZ_DEPTH)) begin
					nz_n[nzc_q[NZI_W-1:0]] = word_act;
					nzc_n = nzc_q + NZC_W'(1);
				end
			end
		end
	end

	// Packed copy of the action list for the snapshot; entries past NZ_DEPTH read as none.
	always_comb begin
		nz_pack = '0;
		for (int i = 0; i < NZ_DEPTH; i++) begin
			nz_pack[i] = nz_n[i];
		end
	end

	// Report state: cleared after the final byte of each report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			odd_q   <= 1'b0;
			first_q <= '0;
			pend_q  <= '0;
			av_q    <= 1'b1;
			uc_q    <= '0;
			nzc_q   <= '0;
			sbz_q   <= 1'b0;
			enter_q <= 1'b0;
		end else if (accept) begin
			if (report.last_byte) begin
				cnt_q   <= '0;
				odd_q   <= 1'b0;
				first_q <= '0;
				pend_q  <= '0;
				av_q    <= 1'b1;
				uc_q    <= '0;
				nzc_q   <= '0;
				sbz_q   <= 1'b0;
				enter_q <= 1'b0;
			end else begin
				cnt_q   <= cnt_n;
				odd_q   <= !odd_q;
				first_q <= first_n;
				pend_q  <= pend_n;
				av_q    <= av_n;
				uc_q    <= uc_n;
				nzc_q   <= nzc_n;
				sbz_q   <= sbz_n;
				enter_q <= enter_n;
			end
		end
	end

	// Compacted list of nonzero usage actions.
	always_ff @(posedge clk) begin
		if (accept && !report.last_byte) begin
			nz_q <= nz_n;
		end
	end

	// Snapshot valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid_s1 <= 1'b0;
		end else if (accept && report.last_byte) begin
			sum_valid_s1 <= 1'b1;
		end else if (sum_take) begin
			sum_valid_s1 <= 1'b0;
		end
	end

	// Snapshot of the finished report.
	always_ff @(posedge clk) begin
		if (accept && report.last_byte) begin
			sum_s1.byte_cnt    <= cnt_n;
			sum_s1.first_byte  <= first_n;
			sum_s1.second_zero <= sbz_n;
			sum_s1.enter_seen  <= enter_n;
			sum_s1.array_valid <= av_n;
			sum_s1.usage_none  <= (uc_n == '0);
			sum_s1.nz_cnt      <= 4'(nzc_n);
			sum_s1.nz_list     <= nz_pack;
		end
	end

endmodule

`default_nettype wire

// ===== design/hrad_emitter.sv =====
`default_nettype none

module hrad_emitter #(
	parameter int USAGE_SLOTS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [3:0]            max_actions,
	input  wire hrad_pkg::report_sum_t sum_s1,
	input  wire logic                  sum_valid_s1,
	output logic                       sum_take,
	hrad_out_if.source                 result
);

	localparam int LIST_N = hrad_pkg::MAX_RESULTS;
	localparam int IDX_W  = $clog2(LIST_N);

	logic [LIST_N-1:0][2:0] list_q, list_n;
	logic [3:0]             cnt_q, cnt_n;
	logic                   has_q, has_n;
	logic [IDX_W-1:0]       idx_q;
	logic                   busy_q;
	logic                   is_last;
	logic                   out_accept;

	// Build the action list of one finished report.
	always_comb begin
		logic [3:0] limit;
		logic [3:0] n;
		logic [3:0] taken;
		logic       use_words;
		logic       use_bitmap;
		logic       none_found;
		logic [2:0] act;

		limit = (max_actions > 4'(LIST_N)) ? 4'(LIST_N) : max_actions;
		use_words  = (sum_s1.byte_cnt >= 4'd2) && sum_s1.array_valid;
		use_bitmap = !use_words && (sum_s1.byte_cnt <= 4'd2);
		list_n = '0;
		n      = '0;
		taken  = '0;
		act    = hrad_pkg::ACT_NONE;
		if (use_words) begin
			list_n = sum_s1.nz_list;
			n      = (sum_s1.nz_cnt < limit) ? sum_s1.nz_cnt : limit;
		end else if (use_bitmap) begin
			for (int i = 0; i < 7; i++) begin
				if (sum_s1.first_byte[i] && {1'b0, taken} < 5'(USAGE_SLOTS)) begin
					taken = taken + 4'd1;
					act   = hrad_pkg::bitmap_action(3'(i));
					if (act != hrad_pkg::ACT_NONE && n < limit) begin
						list_n[n[IDX_W-1:0]] = act;
						n = n + 4'd1;
					end
				end
			end
		end
		none_found = use_words ? sum_s1.usage_none :
			(use_bitmap ? (sum_s1.first_byte[6:0] == 7'd0) : 1'b1);
		// Boot keyboard fallback: Enter in an 8-byte report with byte 1 zero and nothing else found gives Select.
		if (n == 4'd0 && none_found && sum_s1.byte_cnt == 4'd8 && sum_s1.second_zero &&
			sum_s1.enter_seen && limit != 4'd0) begin
			list_n[0] = hrad_pkg::ACT_SELECT;
			n = 4'd1;
		end
		has_n = (n != 4'd0);
		cnt_n = has_n ? n : 4'd1;
	end

	// Output stage: one result per cycle from the held list while result.ready is high.
	assign is_last    = ({1'b0, idx_q} == cnt_q - 4'd1);
	assign out_accept = result.valid && result.ready;
	assign sum_take   = sum_valid_s1 && (!busy_q || (out_accept && is_last));

	assign result.valid       = busy_q;
	assign result.action      = has_q ? list_q[idx_q] : hrad_pkg::ACT_NONE;
	assign result.has_action  = has_q;
	assign result.last_result = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (sum_take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_accept) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// Held result list for the report being sent.
	always_ff @(posedge clk) begin
		if (sum_take) begin
			list_q <= list_n;
			cnt_q  <= cnt_n;
			has_q  <= has_n;
		end
	end

endmodule

`default_nettype wire

// ===== tb/hid_report_action_decoder_unit_test.sv =====
`timescale 1ns / 100ps

module hid_report_action_decoder_unit_test;

	localparam int SLOT_COUNT    = 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 2000;

	// One expected result transaction.
	typedef struct packed {
		logic [2:0] action;
		logic       has_action;
		logic       last_result;
	} action_res_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [3:0] cfg_wr_data;

	hrad_in_if  report_ch ();
	hrad_out_if result_ch ();

	hid_report_action_decoder_unit #(
		.USAGE_SLOTS(SLOT_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.report(report_ch),
		.result(result_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Decoder state mirrored by the testbench.
	logic [3:0]  cur_max_actions;
	logic [3:0]  rpt_len;
	logic        rpt_odd;
	logic [7:0]  rpt_first;
	logic [7:0]  rpt_low;
	logic        rpt_words_ok;
	logic [3:0]  rpt_nused;
	logic [2:0]  rpt_used [SLOT_COUNT];
	logic        rpt_second_zero;
	logic        rpt_enter;

	action_res_t action_q [$];
	logic [7:0]  rpt_buf [$];

	int errors = 0;
	int bytes_sent = 0;
	int reports_sent = 0;
	int results_checked = 0;
	int quiet_cycles = 0;
	int sink_stall = 0;
	logic calm = 1'b0;

	// Free-running clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Random idle length: mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Consumer usage lookup: bit 3 says the usage is known, bits 2:0 give its action.
	function automatic logic [3:0] usage_lookup(input logic [15:0] w);
		case (w)
			hrad_pkg::USG_VOL_UP:     return {1'b1, hrad_pkg::ACT_BRIGHT_UP};
			hrad_pkg::USG_VOL_DOWN:   return {1'b1, hrad_pkg::ACT_BRIGHT_DOWN};
			hrad_pkg::USG_NEXT:       return {1'b1, hrad_pkg::ACT_SCREEN_NEXT};
			hrad_pkg::USG_PREV:       return {1'b1, hrad_pkg::ACT_SCREEN_PREV};
			hrad_pkg::USG_PLAY_PAUSE: return {1'b1, hrad_pkg::ACT_SELECT};
			hrad_pkg::USG_MENU_PICK:  return {1'b1, hrad_pkg::ACT_SELECT};
			hrad_pkg::USG_POWER, hrad_pkg::USG_MENU, hrad_pkg::USG_STOP,
			hrad_pkg::USG_EJECT, hrad_pkg::USG_MUTE, hrad_pkg::USG_AC_HOME,
			hrad_pkg::USG_AC_BACK:    return {1'b1, hrad_pkg::ACT_NONE};
			default:                  return {1'b0, hrad_pkg::ACT_NONE};
		endcase
	endfunction

	// Action carried by one bit of a one-byte bitmap report.
	function automatic logic [2:0] bitmap_bit_action(input int idx);
		case (idx)
			0:       return hrad_pkg::ACT_SCREEN_NEXT;
			1:       return hrad_pkg::ACT_SCREEN_PREV;
			3:       return hrad_pkg::ACT_SELECT;
			5:       return hrad_pkg::ACT_BRIGHT_UP;
			6:       return hrad_pkg::ACT_BRIGHT_DOWN;
			default: return hrad_pkg::ACT_NONE;
		endcase
	endfunction

	function automatic logic [15:0] pick_known_usage();
		case ($urandom_range(0, 12))
			0:       return hrad_pkg::USG_POWER;
			1:       return hrad_pkg::USG_MENU;
			2:       return hrad_pkg::USG_MENU_PICK;
			3:       return hrad_pkg::USG_NEXT;
			4:       return hrad_pkg::USG_PREV;
			5:       return hrad_pkg::USG_STOP;
			6:       return hrad_pkg::USG_EJECT;
			7:       return hrad_pkg::USG_PLAY_PAUSE;
			8:       return hrad_pkg::USG_MUTE;
			9:       return hrad_pkg::USG_VOL_UP;
			10:      return hrad_pkg::USG_VOL_DOWN;
			11:      return hrad_pkg::USG_AC_HOME;
			default: return hrad_pkg::USG_AC_BACK;
		endcase
	endfunction

	task automatic start_new_report();
		rpt_len = 4'd0;
		rpt_odd = 1'b0;
		rpt_first = 8'h00;
		rpt_low = 8'h00;
		rpt_words_ok = 1'b1;
		rpt_nused = 4'd0;
		rpt_second_zero = 1'b0;
		rpt_enter = 1'b0;
	endtask

	// Track one accepted byte; on the final byte, queue the actions of the report.
	task automatic decode_report_byte(input logic [7:0] b, input logic lst);
		logic [15:0] w;
		logic [3:0]  hit;
		logic [2:0]  found [SLOT_COUNT];
		logic [2:0]  picked [hrad_pkg::MAX_RESULTS];
		int          nfound;
		int          nout;
		int          lim;
		action_res_t r;

		if (rpt_len == 4'd0)
			rpt_first = b;
		if (rpt_len == 4'd1)
			rpt_second_zero = (b == 8'h00);
		if (rpt_len >= 4'd2 && rpt_len <= 4'd7 &&
				(b == hrad_pkg::KEY_ENTER || b == hrad_pkg::KEY_KP_ENTER))
			rpt_enter = 1'b1;

		// Pair bytes into little-endian usage words by position parity.
		if (rpt_odd) begin
			w = {b, rpt_low};
			if (w != 16'h0000) begin
				hit = usage_lookup(w);
				if (!hit[3]) begin
					rpt_words_ok = 1'b0;
				end else if (rpt_words_ok && rpt_nused < SLOT_COUNT) begin
					rpt_used[rpt_nused[2:0]] = hit[2:0];
					rpt_nused = rpt_nused + 4'd1;
				end
			end
		end else begin
			rpt_low = b;
		end
		rpt_odd = !rpt_odd;
		if (rpt_len < hrad_pkg::CNT_SAT)
			rpt_len = rpt_len + 4'd1;

		if (!lst)
			return;

		// Pick the usage list or the bitmap reading of the report.
		nfound = 0;
		if (rpt_len >= 4'd2 && rpt_words_ok) begin
			for (int i = 0; i < rpt_nused; i++) begin
				found[nfound] = rpt_used[i];
				nfound++;
			end
		end else if (rpt_len <= 4'd2) begin
			for (int i = 0; i < 7; i++) begin
				if (rpt_first[i] && nfound < SLOT_COUNT) begin
					found[nfound] = bitmap_bit_action(i);
					nfound++;
				end
			end
		end

		lim = (cur_max_actions > hrad_pkg::MAX_RESULTS) ? hrad_pkg::MAX_RESULTS :
			cur_max_actions;
		nout = 0;
		for (int i = 0; i < nfound; i++) begin
			if (nout < lim && found[i] != hrad_pkg::ACT_NONE) begin
				picked[nout] = found[i];
				nout++;
			end
		end

		// Boot keyboard Enter falls back to Select when nothing else was found.
		if (nout == 0 && nfound == 0 && rpt_len == 4'd8 && rpt_second_zero && rpt_enter
				&& lim > 0) begin
			picked[0] = hrad_pkg::ACT_SELECT;
			nout = 1;
		end

		if (nout == 0) begin
			r.action = hrad_pkg::ACT_NONE;
			r.has_action = 1'b0;
			r.last_result = 1'b1;
			action_q.push_back(r);
		end else begin
			for (int i = 0; i < nout; i++) begin
				r.action = picked[i];
				r.has_action = 1'b1;
				r.last_result = (i == nout - 1);
				action_q.push_back(r);
			end
		end
		start_new_report();
	endtask

	// Send one byte transaction after a random gap and track it once accepted.
	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			report_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		report_ch.valid <= 1'b1;
		report_ch.report_byte <= b;
		report_ch.last_byte <= lst;
		do
			@(posedge clk);
		while (!report_ch.ready);
		decode_report_byte(b, lst);
		bytes_sent++;
	endtask

	task automatic send_buffer();
		for (int i = 0; i < rpt_buf.size(); i++)
			send_byte(rpt_buf[i], i == rpt_buf.size() - 1);
		reports_sent++;
	endtask

	// Stop sending and let every queued result come out.
	task automatic drain_results();
		report_ch.valid <= 1'b0;
		while (action_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_max_actions(input logic [3:0] v);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_max_actions = v;
	endtask

	// Random report: mostly usage word lists, then bitmaps, boot keyboard and noise.
	task automatic build_random_report();
		int          kind;
		int          nwords;
		int          len;
		logic [15:0] w;
		rpt_buf.delete();
		kind = $urandom_range(0, 99);
		if (kind < 50) begin
			nwords = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
			repeat (nwords) begin
				case ($urandom_range(0, 19))
					0, 1, 2: w = 16'h0000;
					3:       w = 16'($urandom());
					default: w = pick_known_usage();
				endcase
				rpt_buf.push_back(w[7:0]);
				rpt_buf.push_back(w[15:8]);
			end
			if ($urandom_range(0, 4) == 0)
				rpt_buf.push_back(8'($urandom()));
		end else if (kind < 62) begin
			rpt_buf.push_back(8'($urandom()));
		end else if (kind < 70) begin
			rpt_buf.push_back(8'($urandom()));
			rpt_buf.push_back(8'($urandom()));
		end else if (kind < 85) begin
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 9) : 8;
			rpt_buf.push_back(8'($urandom()));
			rpt_buf.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'h00);
			while (rpt_buf.size() < len) begin
				case ($urandom_range(0, 5))
					0:       rpt_buf.push_back(hrad_pkg::KEY_ENTER);
					1:       rpt_buf.push_back(hrad_pkg::KEY_KP_ENTER);
					2:       rpt_buf.push_back(8'($urandom()));
					default: rpt_buf.push_back(8'h00);
				endcase
			end
		end else begin
			len = $urandom_range(1, 14);
			repeat (len) rpt_buf.push_back(8'($urandom()));
		end
	endtask

	task automatic test_bitmap_reports();
		rpt_buf = '{8'h00};
		send_buffer();
		rpt_buf = '{8'h7F};
		send_buffer();
		rpt_buf = '{8'hFF};
		send_buffer();
		rpt_buf = '{8'h14};
		send_buffer();
	endtask

	task automatic test_usage_words();
		rpt_buf = '{8'hE9, 8'h00};
		send_buffer();
		// Zero words are skipped between usages.
		rpt_buf = '{8'hB5, 8'h00, 8'h00, 8'h00, 8'hB6, 8'h00, 8'hCD, 8'h00, 8'h41, 8'h00};
		send_buffer();
		// A trailing odd byte is ignored.
		rpt_buf = '{8'h23, 8'h02, 8'hEA, 8'h00, 8'h07};
		send_buffer();
		// Known usages with no action give the empty result.
		rpt_buf = '{8'h30, 8'h00, 8'hB7, 8'h00, 8'hE2, 8'h00, 8'h24, 8'h02};
		send_buffer();
	endtask

	task automatic test_rejected_words();
		// A rejected two-byte report falls back to the bitmap of byte 0.
		rpt_buf = '{8'hE9, 8'h01};
		send_buffer();
		rpt_buf = '{8'hE9, 8'h00, 8'hFF, 8'hFF};
		send_buffer();
	endtask

	task automatic test_boot_keyboard();
		rpt_buf = '{8'h00, 8'h00, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_buffer();
		rpt_buf = '{8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h58};
		send_buffer();
		// Nonzero byte 1 blocks the Enter fallback.
		rpt_buf = '{8'h00, 8'h01, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_buffer();
	endtask

	task automatic test_many_usages();
		// More usages than slots, and a report well past the byte counter limit.
		rpt_buf.delete();
		for (int i = 0; i < 12; i++) begin
			rpt_buf.push_back(i[0] ? 8'hEA : 8'hE9);
			rpt_buf.push_back(8'h00);
		end
		send_buffer();
	endtask

	task automatic test_action_limits();
		set_max_actions(4'd0);
		rpt_buf = '{8'h7F};
		send_buffer();
		rpt_buf = '{8'h00, 8'h00, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_buffer();
		set_max_actions(4'd15);
		rpt_buf = '{8'h7F};
		send_buffer();
		test_many_usages();
		set_max_actions(4'd1);
		rpt_buf = '{8'h7F};
		send_buffer();
		set_max_actions(4'd3);
		rpt_buf = '{8'hB6, 8'h00, 8'hB7, 8'h00, 8'hE9, 8'h00, 8'hEA, 8'h00, 8'hB5, 8'h00};
		send_buffer();
	endtask

	task automatic test_random_reports();
		int start;
		logic [3:0] v;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0:       v = 4'd8;
				2:       v = 4'd15;
				4:       v = 4'd2;
				default: v = 4'($urandom_range(0, 15));
			endcase
			set_max_actions(v);
			calm = (p == 2);
			start = bytes_sent;
			while (bytes_sent - start < 18) begin
				build_random_report();
				send_buffer();
			end
		end
		calm = 1'b0;
	endtask

	// Result side: random stalls on ready.
	always @(posedge clk) begin
		if (sink_stall > 0) begin
			result_ch.ready <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else begin
			result_ch.ready <= 1'b1;
			sink_stall <= pick_gap();
		end
	end

	// Compare every accepted result transaction with the oldest expectation.
	always @(posedge clk) begin : check_results
		action_res_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (action_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result action=%0d has_action=%0b last_result=%0b",
					$time, result_ch.action, result_ch.has_action, result_ch.last_result);
			end else begin
				want = action_q.pop_front();
				results_checked++;
				if (result_ch.action !== want.action) begin
					errors++;
					$display("%0t: action expected %0d, got %0d",
						$time, want.action, result_ch.action);
				end
				if (result_ch.has_action !== want.has_action) begin
					errors++;
					$display("%0t: has_action expected %0b, got %0b",
						$time, want.has_action, result_ch.has_action);
				end
				if (result_ch.last_result !== want.last_result) begin
					errors++;
					$display("%0t: last_result expected %0b, got %0b",
						$time, want.last_result, result_ch.last_result);
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel.
	always @(posedge clk) begin
		if (!arst_n || (report_ch.valid && report_ch.ready)
				|| (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, action_q.size());
			$display("hid_report_action_decoder_unit_test NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Test sequence.
	initial begin
		arst_n <= 1'b0;
		report_ch.valid <= 1'b0;
		report_ch.report_byte <= 8'h00;
		report_ch.last_byte <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 4'd0;
		cur_max_actions = hrad_pkg::MAX_ACT_RST;
		start_new_report();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bitmap_reports();
		test_usage_words();
		test_rejected_words();
		test_boot_keyboard();
		test_many_usages();
		test_action_limits();
		test_random_reports();
		drain_results();

		$display("Sent %0d report bytes in %0d reports and checked %0d result transactions,",
			bytes_sent, reports_sent, results_checked);
		$display("with max_actions set from 0 to 15 and random stalls on both channels.");
		if (errors == 0)
			$display("hid_report_action_decoder_unit_test OK");
		else
			$display("hid_report_action_decoder_unit_test NOT OK");
		$finish;
	end

endmodule
